>>> design/rgbenc_pkg.sv
`timescale 1ns / 1ps

package rgbenc_pkg;

  localparam int BITS_PER_LED = 24;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [23:0] DEFAULT_COLOR = 24'h050505;
  localparam logic [7:0] ZERO_HIGH_RESET = 8'd20;
  localparam logic [7:0] ONE_HIGH_RESET = 8'd40;
  localparam logic [7:0] PERIOD_RESET = 8'd63;

  localparam logic [1:0] REG_ZERO_HIGH = 2'd0;
  localparam logic [1:0] REG_ONE_HIGH = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  typedef enum logic [2:0] {
    OP_SET_COLOR   = 3'd0,
    OP_ON          = 3'd1,
    OP_OFF         = 3'd2,
    OP_ALL_ON      = 3'd3,
    OP_BLINK_START = 3'd4,
    OP_BLINK_STOP  = 3'd5,
    OP_BLINK_TICK  = 3'd6,
    OP_EMIT        = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_SWEEP,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [2:0] row;
    logic [2:0] col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] high_ticks;
    logic [7:0] low_ticks;
    logic       bit_value;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic        blink;
    logic        on;
    logic [23:0] color;
  } entry_t;

endpackage

>>> design/rgbenc_ram.sv
`timescale 1ns / 1ps

module rgbenc_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/rgb_led_matrix_bit_encoder_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in_       input      in_valid / in_ready       in_data   (rgbenc_pkg::in_word_t)
// out_      output     out_valid / out_ready     out_data  (rgbenc_pkg::out_word_t)
// APB       input      psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// Set colour, on, off, blink start and blink stop are a read and a write-back of one
// entry of the LED memory. All on and blink tick are a pipelined read-modify-write
// sweep through the whole memory. An emit word first fetches its entry, then gives one
// bit word per cycle while out_ready is high. After reset a clearing pass writes every
// entry before the first word is accepted. A stalled output holds the emitter; the last
// bit may wait in the output register while the next input word is accepted.

module rgb_led_matrix_bit_encoder_unit #(
  parameter int LED_ROWS = 8,
  parameter int LED_COLS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rgbenc_pkg::in_word_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rgbenc_pkg::out_word_t                out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rgbenc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rgbenc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rgbenc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                 pready
);

  localparam int LED_COUNT = LED_ROWS * LED_COLS;
  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
  localparam logic [4:0] LAST_BIT = 5'(rgbenc_pkg::BITS_PER_LED - 1);

  rgbenc_pkg::state_t    state_r, state_nxt;
  rgbenc_pkg::opcode_t   op_r, op_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  hit_r, hit_nxt;
  logic [23:0]           color_r, color_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic                  sw_wr_r, sw_wr_nxt;
  logic [IDX_W-1:0]      sw_addr_r, sw_addr_nxt;
  logic [23:0]           shift_r, shift_nxt;
  logic [4:0]            bit_cnt_r, bit_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rgbenc_pkg::out_word_t out_word_r, out_word_nxt;
  logic [7:0]            zero_high_r, zero_high_nxt;
  logic [7:0]            one_high_r, one_high_nxt;
  logic [7:0]            period_r, period_nxt;

  logic                  in_fire;
  logic                  in_hit;
  logic [IDX_W-1:0]      in_idx;
  logic                  emit_load;
  logic                  cur_bit;
  logic [7:0]            cur_high;
  logic [7:0]            cur_low;
  logic                  cfg_write;
  logic [1:0]            cfg_reg;

  logic                  ram_wr_en;
  logic [IDX_W-1:0]      ram_wr_addr;
  rgbenc_pkg::entry_t    ram_wr_data;
  logic                  ram_rd_en;
  logic [IDX_W-1:0]      ram_rd_addr;
  rgbenc_pkg::entry_t    ram_rd_data;

  rgbenc_ram #(
    .WIDTH($bits(rgbenc_pkg::entry_t)),
    .DEPTH(LED_COUNT)
  ) u_led_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign in_ready = (state_r == rgbenc_pkg::ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign in_hit = (int'(in_data.row) < LED_ROWS) && (int'(in_data.col) < LED_COLS);
  assign in_idx = IDX_W'(int'(in_data.row) * LED_COLS + int'(in_data.col));

  assign emit_load = (state_r == rgbenc_pkg::ST_EMIT) && (!out_valid_r || out_ready);
  assign cur_bit = shift_r[23];
  assign cur_high = cur_bit ? one_high_r : zero_high_r;
  assign cur_low = (period_r > cur_high) ? (period_r - cur_high) : 8'd0;

  assign out_valid = out_valid_r;
  assign out_data = out_word_r;

  assign cfg_write = psel && penable && pwrite;
  assign cfg_reg = paddr[rgbenc_pkg::CFG_ADDR_W-1:2];
  assign pready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rgbenc_pkg::ST_CLEAR: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = rgbenc_pkg::ST_IDLE;
        end
      end
      rgbenc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data.opcode inside {rgbenc_pkg::OP_ALL_ON, rgbenc_pkg::OP_BLINK_TICK}) begin
            state_nxt = rgbenc_pkg::ST_SWEEP;
          end else begin
            state_nxt = rgbenc_pkg::ST_MODIFY;
          end
        end
      end
      rgbenc_pkg::ST_MODIFY: begin
        if (op_r == rgbenc_pkg::OP_EMIT && hit_r) begin
          state_nxt = rgbenc_pkg::ST_EMIT;
        end else begin
          state_nxt = rgbenc_pkg::ST_IDLE;
        end
      end
      rgbenc_pkg::ST_SWEEP: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = rgbenc_pkg::ST_DRAIN;
        end
      end
      rgbenc_pkg::ST_DRAIN: begin
        state_nxt = rgbenc_pkg::ST_IDLE;
      end
      rgbenc_pkg::ST_EMIT: begin
        if (emit_load && bit_cnt_r == LAST_BIT) begin
          state_nxt = rgbenc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rgbenc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    op_nxt = op_r;
    idx_nxt = idx_r;
    hit_nxt = hit_r;
    color_nxt = color_r;
    cnt_nxt = cnt_r;
    sw_wr_nxt = 1'b0;
    sw_addr_nxt = cnt_r;
    shift_nxt = shift_r;
    bit_cnt_nxt = bit_cnt_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt = out_word_r;
    ram_wr_en = 1'b0;
    ram_wr_addr = sw_addr_r;
    ram_wr_data = ram_rd_data;
    ram_rd_en = 1'b0;
    ram_rd_addr = cnt_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rgbenc_pkg::ST_CLEAR: begin
        ram_wr_en = 1'b1;
        ram_wr_addr = cnt_r;
        ram_wr_data.blink = 1'b0;
        ram_wr_data.on = 1'b0;
        ram_wr_data.color = rgbenc_pkg::DEFAULT_COLOR;
        cnt_nxt = (cnt_r == LAST_IDX) ? '0 : cnt_r + 1'b1;
      end
      rgbenc_pkg::ST_IDLE: begin
        ram_rd_addr = in_idx;
        ram_rd_en = in_fire;
        if (in_fire) begin
          op_nxt = in_data.opcode;
          idx_nxt = in_idx;
          hit_nxt = in_hit;
          color_nxt = {in_data.green, in_data.red, in_data.blue};
          cnt_nxt = '0;
          bit_cnt_nxt = '0;
        end
      end
      rgbenc_pkg::ST_MODIFY: begin
        ram_wr_addr = idx_r;
        ram_wr_en = hit_r && (op_r != rgbenc_pkg::OP_EMIT);
        shift_nxt = ram_rd_data.on ? ram_rd_data.color : 24'd0;
        case (op_r)
          rgbenc_pkg::OP_SET_COLOR: begin
            ram_wr_data.color = color_r;
          end
          rgbenc_pkg::OP_ON: begin
            ram_wr_data.on = 1'b1;
          end
          rgbenc_pkg::OP_OFF: begin
            ram_wr_data.on = 1'b0;
          end
          rgbenc_pkg::OP_BLINK_START: begin
            ram_wr_data.blink = 1'b1;
            ram_wr_data.on = 1'b1;
          end
          rgbenc_pkg::OP_BLINK_STOP: begin
            ram_wr_data.blink = 1'b0;
            ram_wr_data.on = 1'b0;
          end
          default: begin
            ram_wr_data = ram_rd_data;
          end
        endcase
      end
      rgbenc_pkg::ST_SWEEP, rgbenc_pkg::ST_DRAIN: begin
        if (state_r == rgbenc_pkg::ST_SWEEP) begin
          ram_rd_en = 1'b1;
          ram_rd_addr = cnt_r;
          sw_wr_nxt = 1'b1;
          sw_addr_nxt = cnt_r;
          cnt_nxt = (cnt_r == LAST_IDX) ? '0 : cnt_r + 1'b1;
        end
        ram_wr_en = sw_wr_r;
        ram_wr_addr = sw_addr_r;
        if (op_r == rgbenc_pkg::OP_ALL_ON) begin
          ram_wr_data.on = 1'b1;
        end else begin
          ram_wr_data.on = ram_rd_data.on ^ ram_rd_data.blink;
        end
      end
      rgbenc_pkg::ST_EMIT: begin
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt.high_ticks = cur_high;
          out_word_nxt.low_ticks = cur_low;
          out_word_nxt.bit_value = cur_bit;
          out_word_nxt.last = (bit_cnt_r == LAST_BIT);
          shift_nxt = {shift_r[22:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r + 5'd1;
        end
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    zero_high_nxt = zero_high_r;
    one_high_nxt = one_high_r;
    period_nxt = period_r;
    if (cfg_write) begin
      case (cfg_reg)
        rgbenc_pkg::REG_ZERO_HIGH: zero_high_nxt = pwdata[7:0];
        rgbenc_pkg::REG_ONE_HIGH:  one_high_nxt = pwdata[7:0];
        rgbenc_pkg::REG_PERIOD:    period_nxt = pwdata[7:0];
        default: begin
          period_nxt = period_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      rgbenc_pkg::REG_ZERO_HIGH: prdata = {24'd0, zero_high_r};
      rgbenc_pkg::REG_ONE_HIGH:  prdata = {24'd0, one_high_r};
      rgbenc_pkg::REG_PERIOD:    prdata = {24'd0, period_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rgbenc_pkg::ST_CLEAR;
      cnt_r <= '0;
      sw_wr_r <= 1'b0;
      out_valid_r <= 1'b0;
      zero_high_r <= rgbenc_pkg::ZERO_HIGH_RESET;
      one_high_r <= rgbenc_pkg::ONE_HIGH_RESET;
      period_r <= rgbenc_pkg::PERIOD_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      sw_wr_r <= sw_wr_nxt;
      out_valid_r <= out_valid_nxt;
      zero_high_r <= zero_high_nxt;
      one_high_r <= one_high_nxt;
      period_r <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    color_r <= color_nxt;
    sw_addr_r <= sw_addr_nxt;
    shift_r <= shift_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    out_word_r <= out_word_nxt;
  end

  a_no_same_entry_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
    else $error("LED memory read and written at the same entry in one cycle");

  a_idle_no_pending_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sw_wr_r)
    else $error("Input accepted while a sweep write is still pending");

  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rgbenc_pkg::ST_EMIT) |-> (bit_cnt_r <= LAST_BIT))
    else $error("Emitter bit count ran past the last bit");

  a_no_output_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rgbenc_pkg::ST_CLEAR) |-> !out_valid_r)
    else $error("Output word presented during the clearing pass");

endmodule
